// ===== rtl/lsm_pkg.sv =====
// Shared constants, register indexes and controller/datapath bundles
// for the Laplacian sharpness measure. No dependencies.
package lsm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int RESP_W     = 13;
  localparam int SUM_W      = 37;
  localparam int MEAN_W     = 21;
  localparam int FRAC_W     = 8;
  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int AREA_W     = COL_W + ROW_W;
  localparam int CNT_W      = $clog2(DVD_W + 1);
  localparam int WIN_N      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic accept;
    logic calc;
    logic acc;
    logic area;
    logic div_step;
    logic load;
  } lsm_cmd_t;

  typedef struct packed {
    logic empty;
    logic frame_end;
    logic small_frame;
    logic div_done;
    logic out_free;
  } lsm_sts_t;

endpackage

// ===== rtl/lsm_datapath.sv =====
// Datapath: config registers, line stores, 3x3 window, kernel, accumulator,
// restoring divider and output register. Depends on lsm_pkg.
module lsm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [lsm_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          frame_start_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [lsm_pkg::MEAN_W-1:0]    mean_sharpness_q8_o,
  output logic [lsm_pkg::SUM_W-1:0]     response_sum_o,
  input  lsm_pkg::lsm_cmd_t             cmd_i,
  output lsm_pkg::lsm_sts_t             sts_o
);
  import lsm_pkg::*;

  logic [CFG_W-1:0]  width_q, height_q;
  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  rd_addr;
  logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  top_q, mid_q, pix_q;
  logic [PIX_W-1:0]  win_q [WIN_N];
  logic [RESP_W-1:0] pos_sum, neg_sum, resp_d, resp_q;
  logic              interior_q;
  logic [SUM_W-1:0]  acc_q, acc_d, sum_q;
  logic              line_end, frame_last;
  logic [COL_W-1:0]  w_m2;
  logic [ROW_W-1:0]  h_m2;
  logic [AREA_W-1:0] area_q, rem_q;
  logic [AREA_W:0]   trial, trial_sub;
  logic              trial_ge;
  logic [DVD_W-1:0]  dvd_q;
  logic [MEAN_W-1:0] quo_q;
  logic [CNT_W-1:0]  div_cnt_q;
  logic              out_valid_q;
  logic [MEAN_W-1:0] mean_q;
  logic [SUM_W-1:0]  out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff      = (width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q;
    h_eff      = (height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;
    line_end   = (CFG_W'(col_q) + CFG_W'(1)) >= w_eff;
    frame_last = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
    rd_addr    = frame_start_i ? '0 : col_q;
    w_m2       = COL_W'(w_eff - CFG_W'(2));
    h_m2       = ROW_W'(h_eff - CFG_W'(2));
  end

  // line stores, read at accept and written back once the window moves
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
      pix_q <= pixel_i;
    end
    if (cmd_i.calc) begin
      upper_mem[col_q]  <= mid_q;
      middle_mem[col_q] <= pix_q;
    end
  end

  always_comb begin
    pos_sum = RESP_W'(win_q[0]) + RESP_W'(top_q) + RESP_W'(win_q[2]) + RESP_W'(pix_q)
            + ((RESP_W'(win_q[1]) + RESP_W'(win_q[3]) + RESP_W'(mid_q)
              + RESP_W'(win_q[5])) << 2);
    neg_sum = (RESP_W'(win_q[4]) << 4) + (RESP_W'(win_q[4]) << 2);
    resp_d  = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
    acc_d   = interior_q ? (acc_q + SUM_W'(resp_q)) : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_N; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.calc) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_q;
      win_q[4] <= mid_q;
      win_q[5] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      resp_q     <= resp_d;
      interior_q <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.accept && frame_start_i) begin
      col_q <= '0;
      row_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      if (line_end) begin
        col_q <= '0;
        if (frame_last) begin
          row_q <= '0;
          acc_q <= '0;
        end else begin
          row_q <= row_q + ROW_W'(1);
          acc_q <= acc_d;
        end
      end else begin
        col_q <= col_q + COL_W'(1);
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && line_end && frame_last) begin
      sum_q <= acc_d;
    end
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    trial_ge  = trial >= {1'b0, area_q};
    trial_sub = trial - {1'b0, area_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.area) begin
      area_q <= AREA_W'(w_m2) * AREA_W'(h_m2);
      dvd_q  <= {sum_q, FRAC_W'(0)};
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? AREA_W'(trial_sub) : AREA_W'(trial);
      dvd_q  <= dvd_q << 1;
      quo_q  <= {quo_q[MEAN_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.area) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mean_q    <= sts_o.small_frame ? '0 : quo_q;
      out_sum_q <= sts_o.small_frame ? '0 : sum_q;
    end
  end

  always_comb begin
    sts_o.empty       = (w_eff == '0) || (h_eff == '0);
    sts_o.frame_end   = line_end && frame_last;
    sts_o.small_frame = (w_eff < CFG_W'(3)) || (h_eff < CFG_W'(3));
    sts_o.div_done    = div_cnt_q == CNT_W'(DVD_W - 1);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o         = out_valid_q;
  assign mean_sharpness_q8_o = mean_q;
  assign response_sum_o      = out_sum_q;

  a_rem_below_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < area_q)
    else $error("divider remainder not below divisor");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> div_cnt_q < CNT_W'(DVD_W))
    else $error("divider stepped past its last bit");

endmodule

// ===== rtl/lsm_ctrl.sv =====
// Controller: sequences pixel read, kernel, accumulate and end-of-frame
// divide. Depends on lsm_pkg.
module lsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output lsm_pkg::lsm_cmd_t cmd_o,
  input  lsm_pkg::lsm_sts_t sts_i
);
  import lsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ACC,
    S_AREA,
    S_DIV,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   accept;

  assign accept = in_valid_i && !stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && !sts_i.empty) begin
            state_q <= S_CALC;
            stall_q <= 1'b1;
          end
        end
        S_CALC: state_q <= S_ACC;
        S_ACC: begin
          if (!sts_i.frame_end) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end else if (sts_i.small_frame) begin
            state_q <= S_LOAD;
          end else begin
            state_q <= S_AREA;
          end
        end
        S_AREA: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.calc     = state_q == S_CALC;
    cmd_o.acc      = state_q == S_ACC;
    cmd_o.area     = state_q == S_AREA;
    cmd_o.div_step = state_q == S_DIV;
    cmd_o.load     = (state_q == S_LOAD) && sts_i.out_free;
  end

  assign in_stall_o = stall_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sts_i.empty) |=> (state_q == S_CALC) && in_stall_o)
    else $error("accepted item did not start processing");

  a_div_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> state_q == S_LOAD)
    else $error("divider finish did not move to load");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input open while busy");

endmodule

// ===== rtl/laplacian_sharpness_measure_unit.sv =====
// Top level of the Laplacian sharpness measure: config port, controller
// and datapath. Depends on lsm_pkg, lsm_ctrl and lsm_datapath.
//
//  channel   handshake                  payload
//  input     in_valid_i / in_stall_o    pixel_i, frame_start_i
//  output    out_valid_o / out_stall_i  mean_sharpness_q8_o, response_sum_o
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each pixel goes through line store read, kernel and accumulate in turn.
// The last pixel of a frame then adds the area multiply, the bit-serial
// divider and the load of the output register, which waits while that
// register is still full; a frame under 3x3 skips the multiply and divide.
// Empty frames (width or height zero) are taken without a stall and give no result.
// Reset is asynchronous, active low; line stores are not cleared.
// A result is held in the output register while out_stall_i is high.
module laplacian_sharpness_measure_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lsm_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lsm_pkg::MEAN_W-1:0]    mean_sharpness_q8_o,
  output logic [lsm_pkg::SUM_W-1:0]     response_sum_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsm_pkg::CFG_W-1:0]     cfg_data_i
);
  import lsm_pkg::*;

  lsm_cmd_t cmd;
  lsm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lsm_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .pixel_i             (pixel_i),
    .frame_start_i       (frame_start_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .mean_sharpness_q8_o (mean_sharpness_q8_o),
    .response_sum_o      (response_sum_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule
